// ===== src/matrix_multiply_engine_unit_defines.svh =====
// Assertion macros shared by the matrix multiply engine RTL.
`ifndef MATRIX_MULTIPLY_ENGINE_UNIT_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define MME_CHK_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mme check failed");

// Next-cycle implication, checked out of reset.
`define MME_CHK_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mme check failed");

`else

`define MME_CHK_IMP(lbl, clk, rstn, ante, cons)
`define MME_CHK_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== src/mme_pkg.sv =====
// Types and constants of the matrix multiply engine.
package mme_pkg;

    localparam int MAX_DIM = 8;
    localparam int DIM_W   = 3;   // width of the row and column fields
    localparam int CNT_W   = 4;   // holds 0..MAX_DIM
    localparam int ELEM_W  = 16;  // signed Q8.8
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int SUM_W   = 40;  // signed Q16.16 with headroom
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_START  = 2'd2;

    localparam logic [1:0] REG_A_ROWS    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_B_COLS    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic [DIM_W-1:0]         row_index;
        logic [DIM_W-1:0]         col_index;
        logic signed [ELEM_W-1:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic [DIM_W-1:0]        out_row;
        logic [DIM_W-1:0]        out_col;
        logic signed [SUM_W-1:0] out_value;
        logic                    is_last;
    } t_out_item;

    // One result element on its way down the chain of cells.
    typedef struct packed {
        logic                    valid;
        logic [DIM_W-1:0]        row;
        logic [DIM_W-1:0]        col;
        logic                    last;
        logic signed [SUM_W-1:0] sum;
    } t_tok;

    // Store write decoded for one cell.
    typedef struct packed {
        logic                     wr_a;
        logic                     wr_b;
        logic [DIM_W-1:0]         addr;
        logic signed [ELEM_W-1:0] data;
    } t_cell_wr;

endpackage

// ===== src/mme_cell.sv =====
// One multiply-accumulate cell: holds column k of A and row k of B.
module mme_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_active,
    input  mme_pkg::t_cell_wr i_wr,
    input  mme_pkg::t_tok     i_tok,
    output mme_pkg::t_tok     o_tok
);
    import mme_pkg::*;

    logic signed [ELEM_W-1:0] r_a_col [MAX_DIM];
    logic signed [ELEM_W-1:0] r_b_row [MAX_DIM];
    logic                     r_valid;
    logic [DIM_W-1:0]         r_row;
    logic [DIM_W-1:0]         r_col;
    logic                     r_last;
    logic signed [SUM_W-1:0]  r_sum;

    logic signed [ELEM_W-1:0] a_sel;
    logic signed [ELEM_W-1:0] b_sel;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  n_sum;

    always_comb begin
        a_sel = r_a_col[i_tok.row];
        b_sel = r_b_row[i_tok.col];
        prod  = a_sel * b_sel;
        if (i_active) begin
            n_sum = i_tok.sum + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
        end else begin
            n_sum = i_tok.sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_a) begin
            r_a_col[i_wr.addr] <= i_wr.data;
        end
        if (i_wr.wr_b) begin
            r_b_row[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_row  <= i_tok.row;
            r_col  <= i_tok.col;
            r_last <= i_tok.last;
            r_sum  <= n_sum;
        end
    end

    always_comb begin
        o_tok.valid = r_valid;
        o_tok.row   = r_row;
        o_tok.col   = r_col;
        o_tok.last  = r_last;
        o_tok.sum   = r_sum;
    end

endmodule

// ===== src/matrix_multiply_engine_unit.sv =====
// Matrix multiply engine top level: command intake, sweep sequencer, cell chain, output.
//
// Computes C = A * B on signed Q8.8 elements, each result an exact signed
// Q16.16 sum in 40 bits. Load items (A or B element) are taken one per
// cycle while the engine is idle; each writes into the cell that owns
// that inner index. A start item launches a sweep: one result element
// per cycle, unless the output stalls, enters a chain of MAX_DIM cells,
// cell k adding A[r][k]*B[k][c] (cells at or beyond inner_dim pass the
// sum through), and leaves through the output register. After a start
// item no new item is taken until the last result (is_last set) has
// been taken. Results come out row-major. Shape registers read 0 as 1 and
// values above MAX_DIM as MAX_DIM. Stores power up undefined: only
// elements that were loaded may be used by a product.
// Registers (APB, 4-bit values): 0x0 a_rows, 0x4 inner_dim, 0x8 b_cols.
`include "matrix_multiply_engine_unit_defines.svh"

module matrix_multiply_engine_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mme_pkg::t_in_item  i_in_item,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mme_pkg::t_out_item o_out_item,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import mme_pkg::*;

    // Clamp a shape register into 1..MAX_DIM.
    function automatic logic [CNT_W-1:0] shape_of(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] s;
        if (v == '0) begin
            s = CNT_W'(1);
        end else if (v > CNT_W'(MAX_DIM)) begin
            s = CNT_W'(MAX_DIM);
        end else begin
            s = v;
        end
        return s;
    endfunction

    // ---------------- configuration ----------------
    logic [CNT_W-1:0] r_a_rows;
    logic [CNT_W-1:0] r_inner_dim;
    logic [CNT_W-1:0] r_b_cols;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows    <= CNT_W'(MAX_DIM);
            r_inner_dim <= CNT_W'(MAX_DIM);
            r_b_cols    <= CNT_W'(MAX_DIM);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_A_ROWS:    r_a_rows    <= pwdata[CNT_W-1:0];
                REG_INNER_DIM: r_inner_dim <= pwdata[CNT_W-1:0];
                REG_B_COLS:    r_b_cols    <= pwdata[CNT_W-1:0];
                default:       ;  // beyond the register list: dropped
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_A_ROWS:    prdata = {{(32-CNT_W){1'b0}}, r_a_rows};
            REG_INNER_DIM: prdata = {{(32-CNT_W){1'b0}}, r_inner_dim};
            REG_B_COLS:    prdata = {{(32-CNT_W){1'b0}}, r_b_cols};
            default:       prdata = '0;
        endcase
    end

    logic [CNT_W-1:0] nr;
    logic [CNT_W-1:0] nk;
    logic [CNT_W-1:0] nc;

    assign nr = shape_of(r_a_rows);
    assign nk = shape_of(r_inner_dim);
    assign nc = shape_of(r_b_cols);

    // ---------------- intake ----------------
    logic r_busy;      // a start is in progress until its last result leaves
    logic r_issuing;   // sequencer still injecting result elements
    logic in_acc;
    logic ld_a;
    logic ld_b;
    logic ld_ok;
    logic start_acc;

    assign o_in_ready = !r_busy;
    assign in_acc     = i_in_valid && o_in_ready;
    assign ld_ok      = (CNT_W'(i_in_item.row_index) < CNT_W'(MAX_DIM)) &&
                        (CNT_W'(i_in_item.col_index) < CNT_W'(MAX_DIM));
    assign ld_a       = in_acc && ld_ok && (i_in_item.opcode == OP_LOAD_A);
    assign ld_b       = in_acc && ld_ok && (i_in_item.opcode == OP_LOAD_B);
    assign start_acc  = in_acc && (i_in_item.opcode == OP_START);

    // ---------------- sweep sequencer ----------------
    logic [DIM_W-1:0] r_iss_row;
    logic [DIM_W-1:0] r_iss_col;
    logic             iss_row_end;
    logic             iss_col_end;
    logic             iss_last;
    logic             adv;        // whole chain moves one step
    logic             r_out_valid;
    t_out_item        r_out_item;

    assign adv         = !r_out_valid || i_out_ready;
    assign iss_row_end = ({1'b0, r_iss_row} == (nr - CNT_W'(1)));
    assign iss_col_end = ({1'b0, r_iss_col} == (nc - CNT_W'(1)));
    assign iss_last    = iss_row_end && iss_col_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_issuing <= 1'b0;
            r_iss_row <= '0;
            r_iss_col <= '0;
        end else begin
            if (start_acc) begin
                r_busy    <= 1'b1;
                r_issuing <= 1'b1;
                r_iss_row <= '0;
                r_iss_col <= '0;
            end else if (r_issuing && adv) begin
                if (iss_last) begin
                    r_issuing <= 1'b0;
                end else if (iss_col_end) begin
                    r_iss_col <= '0;
                    r_iss_row <= r_iss_row + DIM_W'(1);
                end else begin
                    r_iss_col <= r_iss_col + DIM_W'(1);
                end
            end
            // last result taken: engine goes idle
            if (o_out_valid && i_out_ready && o_out_item.is_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // ---------------- cell chain ----------------
    t_tok             w_tok [MAX_DIM+1];
    t_cell_wr         w_wr  [MAX_DIM];
    logic [MAX_DIM-1:0] w_chain_valid;

    assign w_tok[0] = '{valid: r_issuing, row: r_iss_row, col: r_iss_col,
                        last: iss_last, sum: '0};

    for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
        // A[r][k] goes to cell k at row r; B[k][c] goes to cell k at column c.
        assign w_wr[k] = '{
            wr_a: ld_a && (CNT_W'(i_in_item.col_index) == CNT_W'(k)),
            wr_b: ld_b && (CNT_W'(i_in_item.row_index) == CNT_W'(k)),
            addr: ld_a ? i_in_item.row_index : i_in_item.col_index,
            data: i_in_item.element_value
        };

        mme_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (adv),
            .i_active (CNT_W'(k) < nk),
            .i_wr     (w_wr[k]),
            .i_tok    (w_tok[k]),
            .o_tok    (w_tok[k+1])
        );

        assign w_chain_valid[k] = w_tok[k+1].valid;
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= w_tok[MAX_DIM].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_item.out_row   <= w_tok[MAX_DIM].row;
            r_out_item.out_col   <= w_tok[MAX_DIM].col;
            r_out_item.out_value <= w_tok[MAX_DIM].sum;
            r_out_item.is_last   <= w_tok[MAX_DIM].last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ---------------- checks ----------------
    `MME_CHK_IMP(a_issue_busy, i_clk, i_rst_n, r_issuing, r_busy)
    `MME_CHK_IMP(a_chain_busy, i_clk, i_rst_n, w_chain_valid != '0, r_busy)
    `MME_CHK_IMP(a_out_busy, i_clk, i_rst_n, r_out_valid, r_busy)
    `MME_CHK_NXT(a_last_idle, i_clk, i_rst_n,
        o_out_valid && i_out_ready && o_out_item.is_last,
        !r_busy && !r_out_valid && (w_chain_valid == '0))
    `MME_CHK_NXT(a_start_issue, i_clk, i_rst_n, start_acc,
        r_issuing && (r_iss_row == '0) && (r_iss_col == '0))

endmodule

// ===== sim/mme_result_checker.sv =====
// Scoreboard for the matrix multiply engine: tracks loads and shape writes, predicts products.
module mme_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  mme_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  mme_pkg::t_out_item i_out_item,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [3:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import mme_pkg::*;

    logic [CNT_W-1:0]         rows_reg;
    logic [CNT_W-1:0]         inner_reg;
    logic [CNT_W-1:0]         cols_reg;
    logic signed [ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];
    t_out_item                product_q [$];
    int                       mismatches = 0;
    int                       results_seen = 0;

    assign o_fail_count   = mismatches;
    assign o_pending      = product_q.size();
    assign o_result_count = results_seen;

    // 0 reads as 1, anything above MAX_DIM saturates
    function automatic int shape_dim(logic [CNT_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_DIM) return MAX_DIM;
        return int'(raw);
    endfunction

    task automatic queue_product();
        int nr;
        int nk;
        int nc;
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] ea;
        logic signed [SUM_W-1:0] eb;
        t_out_item elem;
        nr = shape_dim(rows_reg);
        nk = shape_dim(inner_reg);
        nc = shape_dim(cols_reg);
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                acc = '0;
                for (int k = 0; k < nk; k++) begin
                    ea = a_mem[r*MAX_DIM + k];
                    eb = b_mem[k*MAX_DIM + c];
                    acc = acc + ea * eb;
                end
                elem.out_row   = DIM_W'(r);
                elem.out_col   = DIM_W'(c);
                elem.out_value = acc;
                elem.is_last   = (r == nr - 1) && (c == nc - 1);
                product_q.push_back(elem);
            end
        end
    endtask

    task automatic note_mismatch(input bit orphan, input t_out_item got, input t_out_item want);
        mismatches++;
        if (mismatches <= 10) begin
            if (orphan)
                $display("[%0t] result with nothing expected: row %0d col %0d value %0d last %0b",
                         $realtime, got.out_row, got.out_col, got.out_value, got.is_last);
            else
                $display("[%0t] result mismatch: got row %0d col %0d value %0d last %0b, %s",
                         $realtime, got.out_row, got.out_col, got.out_value, got.is_last,
                         $sformatf("want row %0d col %0d value %0d last %0b",
                                   want.out_row, want.out_col, want.out_value, want.is_last));
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            rows_reg  = CNT_W'(MAX_DIM);
            inner_reg = CNT_W'(MAX_DIM);
            cols_reg  = CNT_W'(MAX_DIM);
            product_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_A_ROWS:    rows_reg  = i_pwdata[CNT_W-1:0];
                    REG_INNER_DIM: inner_reg = i_pwdata[CNT_W-1:0];
                    REG_B_COLS:    cols_reg  = i_pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_item.opcode)
                    OP_LOAD_A: a_mem[i_in_item.row_index*MAX_DIM + i_in_item.col_index] =
                                   i_in_item.element_value;
                    OP_LOAD_B: b_mem[i_in_item.row_index*MAX_DIM + i_in_item.col_index] =
                                   i_in_item.element_value;
                    OP_START:  queue_product();
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (product_q.size() == 0) begin
                    note_mismatch(1'b1, i_out_item, '0);
                end else begin
                    want = product_q.pop_front();
                    if (i_out_item.out_row !== want.out_row ||
                        i_out_item.out_col !== want.out_col ||
                        i_out_item.out_value !== want.out_value ||
                        i_out_item.is_last !== want.is_last)
                        note_mismatch(1'b0, i_out_item, want);
                end
            end
        end
    end

endmodule

// ===== sim/tb_matrix_multiply_engine_unit.sv =====
// Testbench top for the matrix multiply engine: clock, reset, stimulus, output sink and verdict.
module tb_matrix_multiply_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import mme_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;     // far above the slowest legal run
    localparam int RAND_ITEMS   = 180;        // random-phase item budget
    localparam int SETTLE_CYCLES = MAX_DIM + 8; // engine latency plus margin
    localparam int LONG_STALL   = 300;        // output hold-off used once
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int result_count;
    int cycle_count = 0;

    // stimulus bookkeeping
    bit a_written [MAX_DIM*MAX_DIM];
    bit b_written [MAX_DIM*MAX_DIM];
    int eff_rows = MAX_DIM;
    int eff_inner = MAX_DIM;
    int eff_cols = MAX_DIM;
    int work_items = 0;   // loads and starts accepted
    int ignored_items = 0;
    int products = 0;
    bit quiet = 1'b0;     // when set, neither side idles
    int stall_req = 0;    // bumped by the stimulus to ask for one long hold-off
    int stall_ack = 0;

    matrix_multiply_engine_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    mme_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_in_item      (i_in_item),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_item     (o_out_item),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending);
            $display("status: fail");
            $finish;
        end
    end

    // Result sink. Idles about 20 percent of the time unless quiet; on request
    // it holds ready low for one long hold-off, so the product backs up and
    // the engine stops taking items.
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_req != stall_ack) begin
                stall_ack = stall_req;
                i_out_ready = 1'b0;
                repeat (LONG_STALL - 1) @(negedge i_clk);
            end else begin
                i_out_ready = quiet || ($urandom_range(99) >= 20);
            end
        end
    end

    // Extreme Q8.8 values come up often so the sums hit their corners.
    function automatic logic signed [ELEM_W-1:0] pick_elem();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'shFFFF;
            3: return 16'sh0000;
            default: return ELEM_W'($urandom());
        endcase
    endfunction

    // Raw shape register value: mostly small, sometimes zero, max or oversize.
    function automatic logic [CNT_W-1:0] pick_dim();
        case ($urandom_range(9))
            0: return CNT_W'(0);
            1: return CNT_W'(MAX_DIM);
            2: return CNT_W'(15);
            3: return CNT_W'($urandom_range(MAX_DIM + 1, 15));
            default: return CNT_W'($urandom_range(1, 4));
        endcase
    endfunction

    // Offer one item; called and returns at a falling edge. Valid stays up
    // with a fixed payload until the engine takes the item.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [DIM_W-1:0] row,
                             input logic [DIM_W-1:0] col,
                             input logic signed [ELEM_W-1:0] val);
        while (!quiet && $urandom_range(99) < 20) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = '{opcode: op, row_index: row, col_index: col, element_value: val};
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (op == OP_UNUSED)
            ignored_items++;
        else
            work_items++;
    endtask

    task automatic load_elem(input logic [OP_W-1:0] op, input int row, input int col,
                             input logic signed [ELEM_W-1:0] val);
        send_item(op, DIM_W'(row), DIM_W'(col), val);
        if (op == OP_LOAD_A)
            a_written[row*MAX_DIM + col] = 1'b1;
        else
            b_written[row*MAX_DIM + col] = 1'b1;
    endtask

    // Load every entry the current shape reads that was never written, then
    // start. Start items carry random junk in the ignored fields.
    task automatic run_product();
        for (int r = 0; r < eff_rows; r++)
            for (int k = 0; k < eff_inner; k++)
                if (!a_written[r*MAX_DIM + k]) load_elem(OP_LOAD_A, r, k, pick_elem());
        for (int k = 0; k < eff_inner; k++)
            for (int c = 0; c < eff_cols; c++)
                if (!b_written[k*MAX_DIM + c]) load_elem(OP_LOAD_B, k, c, pick_elem());
        send_item(OP_START, DIM_W'($urandom()), DIM_W'($urandom()), ELEM_W'($urandom()));
        products++;
    endtask

    // Sender pauses until every expected result is back, then gives the
    // engine time to finish any trailing load.
    task automatic settle();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Two-phase register write; upper data bits are random and must be dropped.
    task automatic reg_write(input logic [1:0] idx, input logic [CNT_W-1:0] val);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = ($urandom() & 32'hFFFF_FFF0) | 32'(val);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic int clip_dim(logic [CNT_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_DIM) return MAX_DIM;
        return int'(raw);
    endfunction

    task automatic set_shape(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] inner,
                             input logic [CNT_W-1:0] cols);
        settle();
        reg_write(REG_A_ROWS, rows);
        reg_write(REG_INNER_DIM, inner);
        reg_write(REG_B_COLS, cols);
        eff_rows  = clip_dim(rows);
        eff_inner = clip_dim(inner);
        eff_cols  = clip_dim(cols);
    endtask

    initial begin
        int phase;
        int base;
        int burst;
        int roll;

        // synchronous reset held, then released
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        // ---- directed part ----
        // 1x1x1: largest positive, mixed-sign and most-negative squares
        set_shape(4'd1, 4'd1, 4'd1);
        load_elem(OP_LOAD_A, 0, 0, 16'sh7FFF);
        load_elem(OP_LOAD_B, 0, 0, 16'sh7FFF);
        run_product();
        load_elem(OP_LOAD_B, 0, 0, 16'sh8000);
        run_product();
        load_elem(OP_LOAD_A, 0, 0, 16'sh8000);
        run_product();
        // unused opcode must be dropped without a result
        send_item(OP_UNUSED, 3'd7, 3'd7, 16'shFFFF);
        load_elem(OP_LOAD_A, 0, 0, 16'shFFFF);
        load_elem(OP_LOAD_B, 0, 0, 16'sh0001);
        run_product();
        // zero in every shape register reads as one
        set_shape(4'd0, 4'd0, 4'd0);
        run_product();
        // corner indices
        load_elem(OP_LOAD_A, 7, 7, 16'sh8000);
        load_elem(OP_LOAD_B, 7, 7, 16'sh7FFF);
        // small square product
        set_shape(4'd2, 4'd2, 4'd2);
        run_product();

        // ---- random part ----
        base  = work_items;
        phase = 0;
        while (work_items - base < RAND_ITEMS) begin
            phase++;
            // a run of phases with no idling on either side
            quiet = (phase >= 2 && phase < 4);
            if (phase == 2) begin
                // full 8x8x8 with an oversize inner register; the sink stalls
                // while loads keep coming, so the engine backs up
                set_shape(4'd8, 4'd15, 4'd8);
                run_product();
                stall_req++;
                run_product();
                for (int i = 0; i < 8; i++)
                    load_elem($urandom_range(1) ? OP_LOAD_A : OP_LOAD_B,
                              $urandom_range(7), $urandom_range(7), pick_elem());
            end else begin
                set_shape(pick_dim(), pick_dim(), pick_dim());
            end
            burst = $urandom_range(4, 12);
            for (int i = 0; i < burst; i++) begin
                roll = $urandom_range(99);
                if (roll < 60)
                    load_elem($urandom_range(1) ? OP_LOAD_A : OP_LOAD_B,
                              $urandom_range(7), $urandom_range(7), pick_elem());
                else if (roll < 66)
                    send_item(OP_UNUSED, DIM_W'($urandom()), DIM_W'($urandom()),
                              ELEM_W'($urandom()));
                else
                    run_product();
            end
            run_product();
        end

        // drain and let the pipeline go quiet before the verdict
        settle();
        quiet = 1'b0;

        $display("run: %0d loads/starts, %0d products, %0d ignored items, %0d results checked",
                 work_items, products, ignored_items, result_count);
        $display("shapes 1x1x1 to 8x8x8 incl. zero/oversize registers, one long output stall");
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
